/* rtl/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg: shared definitions for the positional list store
// Sizes, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((COUNT_W > 8) ? COUNT_W : 8) + 1;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int ELEM_W   = 32;
  localparam int OCC_W    = 5;
  localparam int POS_W    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_ALL  = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_INS,
    S_FINAL_INS,
    S_SHIFT_DEL,
    S_READ
  } state_e;

endpackage

/* rtl/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list of signed words
// Elements live front to back in a single-port-write memory with a registered read port.
// ----------------------------------------------------------------------------
// Usage:
//   A command (command_i, value_i, position_i) transfers at a rising edge with
//   start_i high and busy_o low. Each result appears for exactly one cycle
//   with result_valid_o high; the receiver cannot stall, so results are never
//   held back. last_of_run_o marks the final result of a command.
// Command sequencing:
//   Refused commands, insert at the tail and delete of the tail: one result
//   in the cycle after the transfer, busy_o stays low.
//   Insert elsewhere: one memory read/write per moved element in S_SHIFT_INS,
//   then S_FINAL_INS stores the new element.
//   Delete elsewhere: one memory read/write per moved element in S_SHIFT_DEL.
//   Read all: one result per element per cycle, set by the memory read port.
// Reset:
//   rst_ni clears the count and the sequencer; the memory is not cleared,
//   only cells below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [pls_pkg::CMD_W-1:0]      command_i,
  input  logic signed [31:0]             value_i,
  input  logic [pls_pkg::POS_W-1:0]      position_i,
  output logic                           result_valid_o,
  output logic [pls_pkg::STATUS_W-1:0]   status_o,
  output logic signed [pls_pkg::ELEM_W-1:0] element_o,
  output logic [pls_pkg::OCC_W-1:0]      occupancy_o,
  output logic                           last_of_run_o
);

  localparam int DW = pls_pkg::DATA_WIDTH;
  localparam int AW = pls_pkg::ADDR_W;
  localparam int CW = pls_pkg::COUNT_W;
  localparam int PW = pls_pkg::CMP_W;
  localparam int EW = pls_pkg::ELEM_W;

  logic [DW-1:0] mem [pls_pkg::CAPACITY];

  pls_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [DW-1:0]   val_q, val_d;
  logic [DW-1:0]   rd_data_q;

  logic                          res_valid_q, res_valid_d;
  pls_pkg::status_e              status_q, status_d;
  logic signed [EW-1:0]          element_q, element_d;
  logic                          last_q, last_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  pls_pkg::cmd_e cmd;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic [AW-1:0] cnt_a, last_a, pos_a;
  logic          full, empty;

  assign cmd     = pls_pkg::cmd_e'(command_i);
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(cnt_q);
  assign cnt_a   = AW'(cnt_q);
  assign last_a  = AW'(cnt_q - CW'(1));
  assign pos_a   = AW'(position_i - 8'd1);
  assign full    = (cnt_q == CW'(pls_pkg::CAPACITY));
  assign empty   = (cnt_q == '0);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    res_valid_d = 1'b0;
    status_d    = pls_pkg::ST_OK;
    element_d   = '0;
    last_d      = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = rd_data_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;

    case (state_q)
      pls_pkg::S_IDLE: begin
        if (start_i) begin
          case (cmd)
            pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_AT: begin
              if (full) begin
                res_valid_d = 1'b1;
                status_d    = pls_pkg::ST_FULL;
              end else if (cmd == pls_pkg::CMD_INS_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext + PW'(1))) begin
                res_valid_d = 1'b1;
                status_d    = pls_pkg::ST_BADPOS;
              end else begin
                val_d = DW'(value_i);
                if (cmd == pls_pkg::CMD_INS_FRONT) begin
                  idx_d = '0;
                end else if (cmd == pls_pkg::CMD_INS_BACK) begin
                  idx_d = cnt_a;
                end else begin
                  idx_d = pos_a;
                end
                if (idx_d == cnt_a) begin
                  mem_we      = 1'b1;
                  mem_waddr   = cnt_a;
                  mem_wdata   = DW'(value_i);
                  cnt_d       = cnt_q + CW'(1);
                  res_valid_d = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = last_a;
                  ptr_d     = last_a;
                  state_d   = pls_pkg::S_SHIFT_INS;
                end
              end
            end
            pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK, pls_pkg::CMD_DEL_AT: begin
              if (empty) begin
                res_valid_d = 1'b1;
                status_d    = pls_pkg::ST_EMPTY;
              end else if (cmd == pls_pkg::CMD_DEL_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                res_valid_d = 1'b1;
                status_d    = pls_pkg::ST_BADPOS;
              end else begin
                if (cmd == pls_pkg::CMD_DEL_FRONT) begin
                  idx_d = '0;
                end else if (cmd == pls_pkg::CMD_DEL_BACK) begin
                  idx_d = last_a;
                end else begin
                  idx_d = pos_a;
                end
                if (idx_d == last_a) begin
                  cnt_d       = cnt_q - CW'(1);
                  res_valid_d = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_d + AW'(1);
                  ptr_d     = idx_d + AW'(1);
                  state_d   = pls_pkg::S_SHIFT_DEL;
                end
              end
            end
            pls_pkg::CMD_READ_ALL: begin
              if (empty) begin
                res_valid_d = 1'b1;
                status_d    = pls_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = pls_pkg::S_READ;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      pls_pkg::S_SHIFT_INS: begin
        // move cell ptr up by one, walking toward the insert point
        mem_we    = 1'b1;
        mem_waddr = ptr_q + AW'(1);
        if (ptr_q == idx_q) begin
          state_d = pls_pkg::S_FINAL_INS;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end
      pls_pkg::S_FINAL_INS: begin
        mem_we      = 1'b1;
        mem_waddr   = idx_q;
        mem_wdata   = val_q;
        cnt_d       = cnt_q + CW'(1);
        res_valid_d = 1'b1;
        state_d     = pls_pkg::S_IDLE;
      end
      pls_pkg::S_SHIFT_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        if (ptr_q == last_a) begin
          cnt_d       = cnt_q - CW'(1);
          res_valid_d = 1'b1;
          state_d     = pls_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      pls_pkg::S_READ: begin
        res_valid_d = 1'b1;
        element_d   = EW'(signed'(rd_data_q));
        last_d      = (ptr_q == last_a);
        if (ptr_q == last_a) begin
          state_d = pls_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      default: begin
        state_d = pls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pls_pkg::S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign busy_o         = (state_q != pls_pkg::S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign element_o      = element_q;
  assign occupancy_o    = pls_pkg::OCC_W'(cnt_q);
  assign last_of_run_o  = last_q;

endmodule
